/* rtl/core/mts_pkg.sv */
// shared constants and types of the min tracking stack
// no dependencies; used by every module of the block
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int WORD_W = VAL_W + 2;

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(STACK_DEPTH);

  // request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_MIN  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic finish;    // stored word of a pop is on the read register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;  // offered request is a pop of a non-empty stack
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/mts_ctrl.sv */
// controller of the min tracking stack: handshakes and pop sequencing
// depends on mts_pkg
`default_nettype none

module mts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire mts_pkg::sts_t sts,
  output mts_pkg::cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state;
  logic state_next;
  logic load_out;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.finish = (state == S_POP);
  assign load_out   = (cmd.accept && !sts.needs_read) || cmd.finish;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && sts.needs_read) state_next = S_POP;
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mts_datapath.sv */
// datapath of the min tracking stack: stack memory, count, minimum, result register
// depends on mts_pkg
`default_nettype none

module mts_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mts_pkg::cmd_t                     cmd,
  output mts_pkg::sts_t                          sts,
  input  wire logic [1:0]                        req_type,
  input  wire logic signed [mts_pkg::VAL_W-1:0]  push_value,
  output logic signed [mts_pkg::VAL_W-1:0]       result_value,
  output logic [1:0]                             status
);

  logic [mts_pkg::WORD_W-1:0] mem [mts_pkg::STACK_DEPTH];

  logic [mts_pkg::CNT_W-1:0]        count;
  logic signed [mts_pkg::VAL_W-1:0] current_minimum;
  logic [mts_pkg::WORD_W-1:0]       rd_data;

  logic [mts_pkg::CNT_W-1:0]         count_dec;
  logic [mts_pkg::ADDR_W-1:0]        rd_addr;
  logic                              empty;
  logic                              full;
  logic signed [mts_pkg::WORD_W-1:0] x_ext;
  logic signed [mts_pkg::WORD_W-1:0] mn_ext;
  logic signed [mts_pkg::WORD_W-1:0] enc_word;
  logic signed [mts_pkg::WORD_W-1:0] t_word;
  logic signed [mts_pkg::WORD_W-1:0] restored;
  logic                              x_le_mn;
  logic                              t_le_mn;

  assign empty     = (count == '0);
  assign full      = (count == mts_pkg::COUNT_FULL);
  assign count_dec = count - mts_pkg::CNT_W'(1);
  assign rd_addr   = count_dec[mts_pkg::ADDR_W-1:0];

  assign x_ext    = {{2{push_value[mts_pkg::VAL_W-1]}}, push_value};
  assign mn_ext   = {{2{current_minimum[mts_pkg::VAL_W-1]}}, current_minimum};
  assign enc_word = (x_ext <<< 1) - mn_ext;
  assign x_le_mn  = (push_value <= current_minimum);

  assign t_word   = $signed(rd_data);
  assign t_le_mn  = (t_word <= mn_ext);
  assign restored = (mn_ext <<< 1) - t_word;

  assign sts.needs_read = (req_type == mts_pkg::REQ_POP) && !empty;

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == mts_pkg::REQ_PUSH && !full) begin
      mem[count[mts_pkg::ADDR_W-1:0]] <= (!empty && x_le_mn) ? enc_word : x_ext;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      current_minimum <= '0;
    end else if (cmd.finish) begin
      if (t_le_mn) current_minimum <= restored[mts_pkg::VAL_W-1:0];
    end else if (cmd.accept) begin
      unique case (req_type)
        mts_pkg::REQ_PUSH: begin
          if (!full) begin
            count <= count + mts_pkg::CNT_W'(1);
            if (empty || x_le_mn) current_minimum <= push_value;
          end
        end
        mts_pkg::REQ_POP: begin
          if (!empty) count <= count_dec;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_value <= t_le_mn ? current_minimum : t_word[mts_pkg::VAL_W-1:0];
      status       <= mts_pkg::ST_OK;
    end else if (cmd.accept) begin
      unique case (req_type)
        mts_pkg::REQ_PUSH: begin
          result_value <= '0;
          status       <= full ? mts_pkg::ST_FULL : mts_pkg::ST_OK;
        end
        mts_pkg::REQ_POP, mts_pkg::REQ_MIN: begin
          result_value <= empty ? '1 : current_minimum;
          status       <= empty ? mts_pkg::ST_EMPTY : mts_pkg::ST_OK;
        end
        default: begin
          result_value <= '0;
          status       <= mts_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/min_tracking_stack_top.sv */
// top level of the min tracking stack
// depends on mts_pkg, mts_ctrl and mts_datapath
`default_nettype none

// stack of signed 32-bit values that reports its minimum in constant time
// input channel: in_valid/in_ready carry req_type (0 push, 1 pop, 2 minimum)
//   and push_value; one transaction is one request
// output channel: out_valid/out_ready carry result_value and status, exactly
//   one result transaction per request, in request order
// push, minimum read, pops of an empty stack and the unused code give their
//   result on the cycle after acceptance
// a pop of a non-empty stack first registers the stack memory read, then
//   decodes the stored word in the pop state, where no request is taken
// throughput: one request per cycle while the receiver takes the results
// a new request is taken while the result register is full only if that
//   result is being taken in the same cycle; a stalled receiver holds the
//   result register and with it the input side
// reset empties the stack and clears the minimum; memory contents are left
//   as they are and are never read before being written
// a stored word is 34 bits so that the 2x - min encoding cannot overflow
module min_tracking_stack_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       req_type,
  input  wire logic signed [mts_pkg::VAL_W-1:0] push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [mts_pkg::VAL_W-1:0]      result_value,
  output logic [1:0]                            status
);

  // command and status between controller and datapath
  mts_pkg::cmd_t cmd;
  mts_pkg::sts_t sts;

  // handshakes and pop sequencing
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stack memory, count, minimum and result register
  mts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .push_value   (push_value),
    .result_value (result_value),
    .status       (status)
  );

endmodule

`default_nettype wire

/* rtl/core/mts_checker.sv */
// port level checks of the min tracking stack, bound to the top level
// depends on mts_pkg and min_tracking_stack_top
`default_nettype none

module mts_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [1:0]                       req_type,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [mts_pkg::VAL_W-1:0] result_value,
  input wire logic [1:0]                       status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("result changed while stalled");

  // no result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a new transaction is only taken when the pending result drains
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_valid |-> out_ready)
    else $error("input taken over a held result");

  // an empty status always carries all ones
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mts_pkg::ST_EMPTY |-> result_value == '1)
    else $error("empty status without all ones");

  // a push always answers zero
  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == mts_pkg::REQ_PUSH |=> result_value == '0)
    else $error("push result not zero");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .status       (status)
);

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench of min_tracking_stack_top: directed and random push, pop and
// minimum requests checked against a predictor of the stack and its running minimum
// depends on mts_pkg and the rtl of the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int SINK_HOLD_CYCLES = 120;

  // request code with no operation behind it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [mts_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mts_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // one result transaction as the predictor sees it
  typedef struct packed {
    logic signed [mts_pkg::VAL_W-1:0] value;
    logic [1:0]                       status;
  } stack_reply_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       req_type = mts_pkg::REQ_PUSH;
  logic signed [mts_pkg::VAL_W-1:0] push_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [mts_pkg::VAL_W-1:0] result_value;
  logic [1:0]                       status;

  // predictor copy of the block state
  logic signed [mts_pkg::WORD_W-1:0] model_words [mts_pkg::STACK_DEPTH];
  int                                model_depth = 0;
  logic signed [mts_pkg::VAL_W-1:0]  model_min = '0;

  // results owed by the block, oldest first
  stack_reply_t replies_due [$];

  bit idling_on = 1'b1;     // random gaps on both channels
  int sink_hold_len = 0;    // request for a long receiver hold-off
  int mismatch_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  min_tracking_stack_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

  // applies one accepted request to the model and returns the result it owes
  function automatic stack_reply_t stack_op_reply(
      input logic [1:0] kind, input logic signed [mts_pkg::VAL_W-1:0] value);
    stack_reply_t reply;
    longint x;
    longint mn;
    longint word;
    reply.value = '0;
    reply.status = mts_pkg::ST_OK;
    x = value;
    mn = model_min;
    case (kind)
      mts_pkg::REQ_PUSH: begin
        if (model_depth >= mts_pkg::STACK_DEPTH) begin
          reply.status = mts_pkg::ST_FULL;
        end else begin
          if (model_depth != 0 && x <= mn) begin
            // new minimum: keep 2x - min so the old minimum can be recovered
            model_words[model_depth] = mts_pkg::WORD_W'(2 * x - mn);
            model_min = value;
          end else begin
            model_words[model_depth] = mts_pkg::WORD_W'(x);
            if (model_depth == 0) model_min = value;
          end
          model_depth++;
        end
      end
      mts_pkg::REQ_POP: begin
        if (model_depth == 0) begin
          reply.value = '1;
          reply.status = mts_pkg::ST_EMPTY;
        end else begin
          model_depth--;
          word = model_words[model_depth];
          if (word <= mn) begin
            // encoded word: the popped value is the minimum, restore the previous one
            reply.value = mts_pkg::VAL_W'(mn);
            model_min = mts_pkg::VAL_W'(2 * mn - word);
          end else begin
            reply.value = mts_pkg::VAL_W'(word);
          end
        end
      end
      mts_pkg::REQ_MIN: begin
        if (model_depth == 0) begin
          reply.value = '1;
          reply.status = mts_pkg::ST_EMPTY;
        end else begin
          reply.value = model_min;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // idle stretch: mostly short, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // values that hit the interesting compares: extremes, ties with the minimum, small ones
  function automatic logic signed [mts_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 5))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return VAL_MAX - 1;
          3: return VAL_MIN + 1;
          4: return -1;
          default: return 0;
        endcase
      end
      2: return model_min + $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return mts_pkg::REQ_PUSH;
    if (r < 88) return mts_pkg::REQ_POP;
    if (r < 97) return mts_pkg::REQ_MIN;
    return REQ_UNUSED;
  endfunction

  // offers one request transaction and waits for it to be taken
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [mts_pkg::VAL_W-1:0] value);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    push_value <= value;
    do @(posedge clk); while (!in_ready);
    replies_due.push_back(stack_op_reply(kind, value));
  endtask

  // stops offering and waits until every owed result has come back or the drain limit is hit
  task automatic wait_for_replies();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      cycles++;
    end while (replies_due.size() != 0 && cycles < DRAIN_LIMIT);
  endtask

  // empty-stack reads, extreme values, ties with the minimum, stale minimum, unused code
  task automatic test_directed();
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(REQ_UNUSED, 0);
    send_request(mts_pkg::REQ_PUSH, VAL_MAX);
    send_request(mts_pkg::REQ_MIN, 0);
    // widest encoding: 2 * min_int - max_int needs the 34-bit word
    send_request(mts_pkg::REQ_PUSH, VAL_MIN);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_PUSH, VAL_MIN);
    send_request(mts_pkg::REQ_PUSH, 5);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_POP, VAL_MAX);
    send_request(mts_pkg::REQ_MIN, VAL_MIN);
    // stack is empty with a stale minimum of max_int left behind
    send_request(mts_pkg::REQ_PUSH, -1);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_POP, 0);
    send_request(mts_pkg::REQ_PUSH, 3);
    send_request(REQ_UNUSED, 32'hDEAD_BEEF);
    send_request(mts_pkg::REQ_MIN, 0);
    send_request(mts_pkg::REQ_POP, 0);
    wait_for_replies();
  endtask

  task automatic test_random_mix();
    repeat (40) send_request(pick_kind(55), pick_value());
    wait_for_replies();
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (30) send_request(pick_kind(55), pick_value());
    wait_for_replies();
    idling_on = 1'b1;
  endtask

  // receiver holds off while requests keep coming, so the input side backs up
  task automatic test_output_stall();
    sink_hold_len = SINK_HOLD_CYCLES;
    repeat (30) send_request(pick_kind(70), pick_value());
    wait_for_replies();
  endtask

  task automatic test_fill_to_full();
    while (model_depth < mts_pkg::STACK_DEPTH) begin
      if ($urandom_range(0, 31) == 0) send_request(mts_pkg::REQ_MIN, $urandom);
      else send_request(mts_pkg::REQ_PUSH, pick_value());
    end
    // pushes to a full stack are dropped
    repeat (3) send_request(mts_pkg::REQ_PUSH, pick_value());
    send_request(mts_pkg::REQ_MIN, $urandom);
    send_request(mts_pkg::REQ_POP, $urandom);
    send_request(mts_pkg::REQ_PUSH, pick_value());
    send_request(mts_pkg::REQ_PUSH, pick_value());
    wait_for_replies();
  endtask

  task automatic test_drain_from_full();
    repeat (30) begin
      if ($urandom_range(0, 4) == 0) send_request(mts_pkg::REQ_MIN, $urandom);
      else send_request(mts_pkg::REQ_POP, $urandom);
    end
    wait_for_replies();
  endtask

  // receiver: random stalls, plus the long hold-off on request
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        stall = sink_hold_len;
        sink_hold_len = 0;
      end else if (stall == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall = idle_length();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compares each result transaction with the oldest owed one
  always @(posedge clk) begin : reply_check
    stack_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result transaction: result_value %0d status %0d",
               result_value, status);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (result_value !== want.value) begin
          $error("result_value: expected %0d, actual %0d", want.value, result_value);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_back_to_back();
    test_output_stall();
    test_fill_to_full();
    test_drain_from_full();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d result transactions never arrived", replies_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* min_tracking_stack_top.f */
rtl/core/mts_pkg.sv
rtl/core/mts_ctrl.sv
rtl/core/mts_datapath.sv
rtl/core/min_tracking_stack_top.sv
rtl/core/mts_checker.sv
verif/testbench.sv
